@@ rtl/core/case_folded_string_hash_or_literal_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the case-folded string hash core
// Implication forms used by the port checker; all share clock and reset args.
// ----------------------------------------------------------------------------
`ifndef CASE_FOLDED_STRING_HASH_OR_LITERAL_CORE_ASSERT_SVH
`define CASE_FOLDED_STRING_HASH_OR_LITERAL_CORE_ASSERT_SVH

// same-cycle implication
`define CFSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfsh assertion failed");

// next-cycle implication
`define CFSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfsh assertion failed");

`endif

@@ rtl/core/cfsh_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsh_pkg
// Shared widths, codes, control structs and character helpers.
// ----------------------------------------------------------------------------
package cfsh_pkg;

	localparam int CHAR_W     = 8;
	localparam int HASH_W     = 32;
	localparam int PROG_W     = 3;

	localparam logic [PROG_W-1:0] PREFIX_LEN = 3'd5;
	localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

	// literal parser phase
	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_STOP   = 2'd2
	} lit_phase_t;

	// per-cycle control from the top level to the datapath units
	typedef struct packed {
		logic              step;    // non-terminator byte consumed
		logic              finish;  // terminator consumed, result taken
		logic [CHAR_W-1:0] ch;
	} step_ctl_t;

	typedef struct packed {
		logic              is_literal;
		logic [HASH_W-1:0] value;
	} lit_result_t;

	// "hash:" prefix, byte by position
	function automatic logic [CHAR_W-1:0] prefix_byte(input logic [PROG_W-1:0] idx);
		logic [CHAR_W-1:0] b;
		case (idx)
			3'd0:    b = 8'h68; // h
			3'd1:    b = 8'h61; // a
			3'd2:    b = 8'h73; // s
			3'd3:    b = 8'h68; // h
			3'd4:    b = 8'h3A; // :
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

@@ rtl/core/cfsh_byte_if.sv @@
// ----------------------------------------------------------------------------
// cfsh_byte_if
// Valid/ready channel carrying one string byte per transaction.
// ----------------------------------------------------------------------------
interface cfsh_byte_if;
	logic                        valid;
	logic                        ready;
	logic [cfsh_pkg::CHAR_W-1:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

@@ rtl/core/cfsh_result_if.sv @@
// ----------------------------------------------------------------------------
// cfsh_result_if
// Valid/ready channel carrying one hash or literal result per transaction.
// ----------------------------------------------------------------------------
interface cfsh_result_if;
	logic                        valid;
	logic                        ready;
	logic [cfsh_pkg::HASH_W-1:0] hash_value;
	logic                        was_literal;

	modport source (output valid, output hash_value, output was_literal, input ready);
	modport sink   (input valid, input hash_value, input was_literal, output ready);
endinterface

@@ rtl/core/case_folded_string_hash_or_literal_core.sv @@
// ----------------------------------------------------------------------------
// case_folded_string_hash_or_literal_core
// Case-folded one-at-a-time string hash with a "hash:" decimal literal override.
// ----------------------------------------------------------------------------
// Feed a C string one byte per transaction on chars; a zero byte ends it and
// produces exactly one transaction on results. Letters A..Z are folded to
// lower case, each byte is sign-extended and mixed with the one-at-a-time
// round, and the final avalanche is applied on the terminator. A string that
// starts with the exact bytes "hash:" and has at least one more byte instead
// returns its atoi-style decimal value (wrapping mod 2^32) with was_literal
// set. Throughput is one byte per cycle, strings back to back with no gap,
// except when a terminator stalls. The terminator passes through the input
// register and then the result register before results.valid. The only stall
// is a terminator that finds the result register still holding an
// unclaimed result; it waits in the input register until results.ready.
// ----------------------------------------------------------------------------
module case_folded_string_hash_or_literal_core (
	input logic           clk,
	input logic           arst_n,
	cfsh_byte_if.sink     chars,
	cfsh_result_if.source results
);
	import cfsh_pkg::*;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// result register
	logic              res_valid_q;
	logic [HASH_W-1:0] res_hash_q;
	logic              res_lit_q;

	logic              out_free;
	logic              is_term;
	logic              advance;
	step_ctl_t         ctl;
	logic [HASH_W-1:0] final_hash;
	lit_result_t       lit;

	// result register can take a new value this cycle
	assign out_free = !res_valid_q || results.ready;
	assign is_term  = (char_s1 == '0);
	// non-terminator bytes never touch the result register, so they always move
	assign advance  = valid_s1 && (!is_term || out_free);

	assign chars.ready = !valid_s1 || advance;

	always_comb begin
		ctl.step   = valid_s1 && !is_term;
		ctl.finish = valid_s1 && is_term && out_free;
		ctl.ch     = char_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_byte;
		end
	end

	cfsh_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.final_hash(final_hash)
	);

	cfsh_literal u_literal (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.res   (lit)
	);

	// result register: loads on terminator, drops when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_hash_q <= lit.is_literal ? lit.value : final_hash;
			res_lit_q  <= lit.is_literal;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.hash_value  = res_hash_q;
	assign results.was_literal = res_lit_q;

endmodule

@@ rtl/core/cfsh_mix.sv @@
// ----------------------------------------------------------------------------
// cfsh_mix
// One-at-a-time mix accumulator with case folding and the final avalanche.
// ----------------------------------------------------------------------------
module cfsh_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfsh_pkg::step_ctl_t         ctl,
	output logic [cfsh_pkg::HASH_W-1:0] final_hash
);
	import cfsh_pkg::*;

	logic [HASH_W-1:0] acc_q;
	logic [CHAR_W-1:0] folded;
	logic [HASH_W-1:0] ext, h1, h2, h3;
	logic [HASH_W-1:0] f1, f2;

	always_comb begin
		folded = ctl.ch;
		if ((ctl.ch >= 8'h41) && (ctl.ch <= 8'h5A)) begin
			folded = ctl.ch + CASE_BIT;
		end
		// signed char
		ext = {{(HASH_W-CHAR_W){folded[CHAR_W-1]}}, folded};
		h1  = acc_q + ext;
		h2  = h1 + (h1 << 10);
		h3  = h2 ^ (h2 >> 6);
	end

	always_comb begin
		f1         = acc_q + (acc_q << 3);
		f2         = f1 ^ (f1 >> 11);
		final_hash = f2 + (f2 << 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.finish) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= h3;
		end
	end

endmodule

@@ rtl/core/cfsh_literal.sv @@
// ----------------------------------------------------------------------------
// cfsh_literal
// "hash:" prefix matcher and atoi-style decimal parser.
// ----------------------------------------------------------------------------
module cfsh_literal (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfsh_pkg::step_ctl_t   ctl,
	output cfsh_pkg::lit_result_t res
);
	import cfsh_pkg::*;

	logic [PROG_W-1:0] prog_q, prog_d;
	logic              failed_q, failed_d;
	logic              past_q, past_d;
	logic [HASH_W-1:0] value_q, value_d;
	lit_phase_t        phase_q, phase_d;
	logic              neg_q, neg_d;

	logic [CHAR_W-1:0] dval;
	logic [HASH_W-1:0] accum;
	logic              digit;

	always_comb begin
		dval  = ctl.ch - 8'h30;
		digit = is_digit(ctl.ch);
		accum = (value_q << 3) + (value_q << 1) + {{(HASH_W-CHAR_W){1'b0}}, dval};
	end

	// next state
	always_comb begin
		prog_d   = prog_q;
		failed_d = failed_q;
		past_d   = past_q;
		value_d  = value_q;
		phase_d  = phase_q;
		neg_d    = neg_q;
		if (ctl.step && !failed_q) begin
			if (prog_q < PREFIX_LEN) begin
				if (ctl.ch == prefix_byte(prog_q)) begin
					prog_d = prog_q + 3'd1;
				end else begin
					failed_d = 1'b1;
				end
			end else begin
				past_d = 1'b1;
				unique case (phase_q)
					PH_SKIP: begin
						if (is_space(ctl.ch)) begin
							phase_d = PH_SKIP;
						end else if ((ctl.ch == 8'h2B) || (ctl.ch == 8'h2D)) begin
							neg_d   = (ctl.ch == 8'h2D);
							phase_d = PH_DIGITS;
						end else if (digit) begin
							value_d = accum;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_STOP;
						end
					end
					PH_DIGITS: begin
						if (digit) begin
							value_d = accum;
						end else begin
							phase_d = PH_STOP;
						end
					end
					default: begin
						phase_d = PH_STOP;
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res.is_literal = !failed_q && (prog_q == PREFIX_LEN) && past_q;
		res.value      = neg_q ? (HASH_W'(0) - value_q) : value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q   <= '0;
			failed_q <= 1'b0;
			past_q   <= 1'b0;
			value_q  <= '0;
			phase_q  <= PH_SKIP;
			neg_q    <= 1'b0;
		end else if (ctl.finish) begin
			prog_q   <= '0;
			failed_q <= 1'b0;
			past_q   <= 1'b0;
			value_q  <= '0;
			phase_q  <= PH_SKIP;
			neg_q    <= 1'b0;
		end else begin
			prog_q   <= prog_d;
			failed_q <= failed_d;
			past_q   <= past_d;
			value_q  <= value_d;
			phase_q  <= phase_d;
			neg_q    <= neg_d;
		end
	end

endmodule

@@ rtl/core/cfsh_checker.sv @@
// ----------------------------------------------------------------------------
// cfsh_checker
// Port-level checks on the hash core, bound to the top level.
// ----------------------------------------------------------------------------
`include "case_folded_string_hash_or_literal_core_assert.svh"

module cfsh_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [cfsh_pkg::CHAR_W-1:0] in_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [cfsh_pkg::HASH_W-1:0] out_hash,
	input logic                        out_lit
);

	// stalled result stays up with its payload
	`CFSH_ASSERT_NXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CFSH_ASSERT_NXT(a_res_stable, clk, arst_n, out_valid && !out_ready, $stable(out_hash) && $stable(out_lit))

	// an offered result carries a fully known payload
	`CFSH_ASSERT_IMP(a_res_known, clk, arst_n, out_valid, !$isunknown(out_hash) && !$isunknown(out_lit))

	// an offered input byte is fully known
	`CFSH_ASSERT_IMP(a_in_known, clk, arst_n, in_valid, !$isunknown(in_byte))

	// an empty result register never backs up the input
	`CFSH_ASSERT_IMP(a_no_false_stall, clk, arst_n, !out_valid, in_ready)

endmodule

bind case_folded_string_hash_or_literal_core cfsh_checker u_cfsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (chars.valid),
	.in_ready (chars.ready),
	.in_byte  (chars.char_byte),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_hash (results.hash_value),
	.out_lit  (results.was_literal)
);

@@ test/tb_case_folded_string_hash_or_literal_core.sv @@
// ----------------------------------------------------------------------------
// tb_case_folded_string_hash_or_literal_core
// Self-checking bench for the case-folded string hash / "hash:" literal core.
// ----------------------------------------------------------------------------
// Strings go in one byte per transaction, and each ends with a zero byte. A
// scoreboard class tracks the per-string hash and literal state of the core
// and queues one expected result per terminator. Every result transaction is
// then compared, field by field, against the oldest queued entry. There is a
// short hand-picked set of strings first. Random strings follow, mostly
// well-formed "hash:" literals with whitespace, signs, long digit runs and
// trailing junk, plus prefixes that break early and plain noise strings.
// Sender gaps and receiver stalls change over four phases.
// ----------------------------------------------------------------------------
module tb_case_folded_string_hash_or_literal_core;
	import cfsh_pkg::*;

	typedef logic [CHAR_W-1:0] byte_q_t[$];

	// bytes of the literal prefix, first byte in the top lane
	localparam logic [5*CHAR_W-1:0] PREFIX        = "hash:";
	localparam int unsigned         RAND_BYTES    = 1650;
	// cycles with no transaction on either side before the run is called hung
	localparam int unsigned         STALL_LIMIT   = 5000;
	// leave some slack after the last result
	localparam int unsigned         DRAIN_CYCLES  = 16;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the core's per-string state and holds expected results
	// ------------------------------------------------------------------------
	class hash_scoreboard;
		lit_result_t       expected_q[$];
		int unsigned       errors;

		logic [HASH_W-1:0] mix;        // running one-at-a-time hash
		logic [PROG_W-1:0] matched;    // prefix bytes matched so far
		logic              prefix_bad; // some byte differed from the prefix
		logic              tail_seen;  // a byte followed the full prefix
		logic [HASH_W-1:0] magnitude;  // literal digits, mod 2^32
		lit_phase_t        phase;
		logic              negative;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mix        = '0;
			matched    = '0;
			prefix_bad = 1'b0;
			tail_seen  = 1'b0;
			magnitude  = '0;
			phase      = PH_SKIP;
			negative   = 1'b0;
		endfunction

		// atoi-style parse of the bytes after the prefix
		function void parse_literal(logic [CHAR_W-1:0] c);
			logic digit;
			digit = (c >= "0") && (c <= "9");
			if (phase == PH_SKIP) begin
				if (c == " " || (c >= 8'h09 && c <= 8'h0D))
					return;
				if (c == "+" || c == "-") begin
					negative = (c == "-");
					phase    = PH_DIGITS;
					return;
				end
				phase = digit ? PH_DIGITS : PH_STOP;
			end
			if (phase == PH_DIGITS) begin
				if (digit)
					magnitude = magnitude * 32'd10 + (HASH_W'(c) - 32'h30);
				else
					phase = PH_STOP;
			end
		endfunction

		// called for every accepted input transaction
		function void note_byte(logic [CHAR_W-1:0] c);
			logic [CHAR_W-1:0] folded;
			logic [HASH_W-1:0] h;
			lit_result_t       res;
			if (c != '0) begin
				folded = (c >= "A" && c <= "Z") ? (c + CASE_BIT) : c;
				h = mix + {{(HASH_W-CHAR_W){folded[CHAR_W-1]}}, folded};
				h = h + (h << 10);
				h = h ^ (h >> 6);
				mix = h;
				if (!prefix_bad && matched < PREFIX_LEN) begin
					if (c == PREFIX[(4 - int'(matched))*CHAR_W +: CHAR_W])
						matched++;
					else
						prefix_bad = 1'b1;
				end else if (!prefix_bad) begin
					tail_seen = 1'b1;
					parse_literal(c);
				end
				return;
			end
			// terminator: literal if the full prefix plus more came in
			if (!prefix_bad && matched == PREFIX_LEN && tail_seen) begin
				res.value      = negative ? -magnitude : magnitude;
				res.is_literal = 1'b1;
			end else begin
				h = mix;
				h = h + (h << 3);
				h = h ^ (h >> 11);
				h = h + (h << 15);
				res.value      = h;
				res.is_literal = 1'b0;
			end
			expected_q.push_back(res);
			clear();
		endfunction

		// called for every accepted result transaction
		function void check_result(logic [HASH_W-1:0] value, logic is_literal);
			lit_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: hash_value %h was_literal %b",
					$time, value, is_literal);
				return;
			end
			want = expected_q.pop_front();
			if (value !== want.value) begin
				errors++;
				$display("%0t: hash_value mismatch: expected %h actual %h",
					$time, want.value, value);
			end
			if (is_literal !== want.is_literal) begin
				errors++;
				$display("%0t: was_literal mismatch: expected %b actual %b",
					$time, want.is_literal, is_literal);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block under test
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfsh_byte_if   chars_if();
	cfsh_result_if results_if();

	case_folded_string_hash_or_literal_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	hash_scoreboard sb = new();

	// idling odds in percent, changed per phase by the stimulus
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned rand_sent      = 0;
	int unsigned quiet_cycles   = 0;

	// ------------------------------------------------------------------------
	// Result side: check every transaction, then pick next cycle's ready.
	// Values are read right after the edge, so they are the pre-edge ones.
	// ------------------------------------------------------------------------
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready)
				sb.check_result(results_if.hash_value, results_if.was_literal);
			results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: cycles in which neither channel moved a transaction
	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_case_folded_string_hash_or_literal_core: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// one byte: random gap first, then hold until the core takes it
	task automatic send_byte(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_byte <= c;
		do
			@(posedge clk);
		while (!chars_if.ready);
		sb.note_byte(c);
	endtask

	// a whole string plus its zero terminator
	task automatic send_string(input byte_q_t s);
		foreach (s[i])
			send_byte(s[i]);
		send_byte('0);
	endtask

	function automatic byte_q_t text(input string t);
		byte_q_t q;
		for (int i = 0; i < t.len(); i++)
			q.push_back(t[i]);
		return q;
	endfunction

	function automatic logic [CHAR_W-1:0] any_char();
		return CHAR_W'($urandom_range(1, 255));
	endfunction

	// one of 0x09..0x0E or space; all but 0x0E are whitespace bytes atoi skips
	function automatic logic [CHAR_W-1:0] blank_char();
		int unsigned r;
		r = $urandom_range(0, 6);
		return (r == 6) ? 8'h20 : CHAR_W'(8'h09 + r);
	endfunction

	// "hash:" + blanks + sign + digits + junk; some of these are only the prefix
	function automatic byte_q_t literal_string();
		byte_q_t     q;
		int unsigned n;
		q = text("hash:");
		n = $urandom_range(0, 3);
		repeat (n) q.push_back(blank_char());
		case ($urandom_range(0, 4))
			0:       q.push_back("+");
			1:       q.push_back("-");
			2:       if ($urandom_range(0, 3) == 0) q.push_back(any_char());
			default: ;
		endcase
		// long runs push the value past 32 bits
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 6);
		repeat (n) q.push_back(CHAR_W'("0" + $urandom_range(0, 9)));
		if ($urandom_range(0, 3) == 0) begin
			q.push_back(any_char());
			n = $urandom_range(0, 3);
			repeat (n) q.push_back(CHAR_W'("0" + $urandom_range(0, 9)));
		end
		return q;
	endfunction

	// prefix broken at a random place, maybe by a case change
	function automatic byte_q_t broken_string();
		byte_q_t     q;
		int unsigned pos;
		int unsigned n;
		q   = text("hash:");
		pos = $urandom_range(0, 4);
		if ($urandom_range(0, 1) == 0 && q[pos] >= "a" && q[pos] <= "z")
			q[pos] = q[pos] - CASE_BIT;
		else
			q[pos] = any_char();
		if ($urandom_range(0, 2) == 0)
			q = q[0:pos];
		n = $urandom_range(0, 5);
		repeat (n) q.push_back(any_char());
		return q;
	endfunction

	// short mixed-case and high-byte noise
	function automatic byte_q_t noise_string();
		byte_q_t     q;
		int unsigned n;
		n = $urandom_range(0, 10);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0:       q.push_back(CHAR_W'("A" + $urandom_range(0, 25)));
				1:       q.push_back(CHAR_W'($urandom_range(8'h80, 8'hFF)));
				default: q.push_back(any_char());
			endcase
		end
		return q;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		byte_q_t     s;
		int unsigned pick;

		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked strings, no idling
		send_string(s);                         // empty string hashes to zero
		send_string(text("hash:"));             // bare prefix is hashed
		send_string(text("hash:x"));            // prefix, no digits: literal 0
		send_string(text("hash:\t-9"));         // blank then sign
		s = text("AZ");                         // folding and sign extension
		s.push_back(8'h80);
		s.push_back(8'hFF);
		s.push_back(8'h7F);
		send_string(s);

		// random strings over four idling phases
		while (rand_sent < RAND_BYTES) begin
			case (rand_sent * 4 / RAND_BYTES)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 6)
				s = literal_string();
			else if (pick < 8)
				s = broken_string();
			else
				s = noise_string();
			send_string(s);
			rand_sent += s.size() + 1;
		end

		chars_if.valid <= 1'b0;
		recv_stall_pct = 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("tb_case_folded_string_hash_or_literal_core: done, clean");
		else
			$display("tb_case_folded_string_hash_or_literal_core: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cfsh_pkg.sv
rtl/core/cfsh_byte_if.sv
rtl/core/cfsh_result_if.sv
rtl/core/cfsh_mix.sv
rtl/core/cfsh_literal.sv
rtl/core/case_folded_string_hash_or_literal_core.sv
rtl/core/cfsh_checker.sv
test/tb_case_folded_string_hash_or_literal_core.sv
